// ===== hdl/lsdf_pkg.sv =====
`default_nettype none
package lsdf_pkg;

    localparam int LIMIT_W = 20;
    localparam int COUNT_W = 8;
    localparam int SUM_W = 30;
    localparam int EXP_W = 5;

    localparam int DEF_MAX_N = 1048576;
    localparam int DEF_PRIME_DEPTH = 131072;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'hFFFFF;
    localparam logic [SUM_W:0] MODULUS = 31'd1000000007;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_Q_RD,
        OP_Q_OUT,
        OP_INIT,
        OP_CLEAR,
        OP_RD_I,
        OP_CHK_I,
        OP_PRIME_WR,
        OP_J_RD,
        OP_J_P,
        OP_J_K,
        OP_ND_ADD,
        OP_ND_WR,
        OP_DV_M,
        OP_DV_CAP,
        OP_DV_MUL,
        OP_DV_WR,
        OP_NEXT_I,
        OP_DONE
    } dp_op_t;

    typedef struct packed {
        logic prime;
        logic clr_last;
        logic lim_small;
        logic j_end;
        logic k_stop;
        logic divides;
        logic mm_busy;
        logic i_last;
        logic out_free;
    } dp_status_t;

    // Modular addition of two residues.
    function automatic logic [SUM_W-1:0] add_mod(input logic [SUM_W-1:0] x,
                                                 input logic [SUM_W-1:0] y);
        logic [SUM_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= MODULUS) begin
            s = s - MODULUS;
        end
        return s[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/lsdf_ram.sv =====
`default_nettype none
module lsdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/lsdf_mulmod.sv =====
`default_nettype none
module lsdf_mulmod (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [lsdf_pkg::SUM_W-1:0]   a,
    input  wire logic [lsdf_pkg::SUM_W-1:0]   b,
    output logic                              busy,
    output logic      [lsdf_pkg::SUM_W-1:0]   result
);
    import lsdf_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] r_reg;
    logic [SUM_W-1:0] a_reg;
    logic [SUM_W-1:0] b_reg;
    logic [SUM_W:0]   dbl;
    logic [SUM_W-1:0] dbl_mod;
    logic [SUM_W-1:0] r_next;

    // Interleaved multiply: double the partial result, add a when the
    // multiplier bit is set, reducing after each step. Operands are residues.
    always_comb begin
        dbl = {r_reg, 1'b0};
        if (dbl >= MODULUS) begin
            dbl = dbl - MODULUS;
        end
        dbl_mod = dbl[SUM_W-1:0];
        r_next = add_mod(dbl_mod, b_reg[SUM_W-1] ? a_reg : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == '0) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= CNT_W'(SUM_W - 1);
            r_reg <= '0;
            a_reg <= a;
            b_reg <= b;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            r_reg <= r_next;
            b_reg <= {b_reg[SUM_W-2:0], 1'b0};
        end
    end

    assign busy = busy_reg;
    assign result = r_reg;

endmodule
`default_nettype wire

// ===== hdl/lsdf_dp.sv =====
`default_nettype none
module lsdf_dp #(
    parameter int MAX_N = lsdf_pkg::DEF_MAX_N,
    parameter int PRIME_DEPTH = lsdf_pkg::DEF_PRIME_DEPTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire lsdf_pkg::dp_op_t               op,
    output lsdf_pkg::dp_status_t                status,
    input  wire logic [lsdf_pkg::LIMIT_W-1:0]   s_query_value,
    input  wire logic                           cfg_wr_en,
    input  wire logic [lsdf_pkg::LIMIT_W-1:0]   cfg_wr_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_status,
    output logic      [lsdf_pkg::COUNT_W-1:0]   m_divisor_count,
    output logic      [lsdf_pkg::SUM_W-1:0]     m_divisor_square_sum
);
    import lsdf_pkg::*;

    localparam int AW = $clog2(MAX_N);
    localparam int PAW = $clog2(PRIME_DEPTH);
    localparam int PCW = $clog2(PRIME_DEPTH + 1);
    localparam int CW = (AW > LIMIT_W) ? AW : LIMIT_W;
    localparam logic [CW-1:0] TOP_N = CW'(MAX_N - 1);

    logic [LIMIT_W-1:0] limit_reg;
    logic [AW-1:0]      blim_reg;
    logic               ready_reg;
    logic [LIMIT_W-1:0] q_reg;
    logic [AW-1:0]      clr_reg;
    logic [AW-1:0]      i_reg;
    logic [PCW-1:0]     j_reg;
    logic [PCW-1:0]     ptot_reg;
    logic [AW-1:0]      p_reg;
    logic [2*AW-1:0]    k_reg;
    logic [AW-1:0]      spf_i_reg;
    logic [COUNT_W-1:0] cnt_i_reg;
    logic [SUM_W-1:0]   ss_i_reg;
    logic [EXP_W-1:0]   e_reg;
    logic [COUNT_W-1:0] cntm_reg;
    logic [SUM_W-1:0]   ssm_reg;
    logic               m_valid_reg;
    logic               status_reg;
    logic [COUNT_W-1:0] cnt_out_reg;
    logic [SUM_W-1:0]   ss_out_reg;

    logic [CW-1:0]      lim_ext;
    logic [AW-1:0]      lim_clamp;
    logic               k_stop;
    logic               divides;
    logic               k_live;
    logic               plist_full;
    logic               q_err;
    logic [COUNT_W:0]   cnt_dbl;
    logic [COUNT_W-1:0] cnt_dbl_sat;
    logic [EXP_W:0]     e_plus;
    logic [COUNT_W+EXP_W:0] cnt_prod;
    logic [COUNT_W-1:0] cnt_prod_sat;
    logic [EXP_W-1:0]   e_new;

    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      tab_raddr;
    logic               mark_we, spf_we, exp_we, cof_we, cnt_we, ss_we, pl_we;
    logic               mark_wd, mark_rd;
    logic [AW-1:0]      spf_wd, spf_rd, cof_wd, cof_rd, pl_rd;
    logic [EXP_W-1:0]   exp_wd, exp_rd;
    logic [COUNT_W-1:0] cnt_wd, cnt_rd;
    logic [SUM_W-1:0]   ss_wd, ss_rd;

    logic               mm_start;
    logic [SUM_W-1:0]   mm_a, mm_b, mm_res;
    logic               mm_busy;

    // Build limit is the register clamped to the table size.
    assign lim_ext = CW'(limit_reg);
    assign lim_clamp = (lim_ext > TOP_N) ? AW'(TOP_N) : AW'(lim_ext);

    assign k_stop = (p_reg == '0) || (k_reg > (2*AW)'(blim_reg));
    // Primes are walked in increasing order, so a listed prime divides i
    // exactly when it is the smallest prime factor recorded for i.
    assign divides = (spf_i_reg == p_reg);
    assign k_live = (op == OP_J_K) && !k_stop;
    assign plist_full = (ptot_reg == PCW'(PRIME_DEPTH));
    assign q_err = !ready_reg || (q_reg == '0) || (CW'(q_reg) > CW'(blim_reg));

    assign cnt_dbl = {cnt_i_reg, 1'b0};
    assign cnt_dbl_sat = cnt_dbl[COUNT_W] ? '1 : cnt_dbl[COUNT_W-1:0];
    assign e_new = exp_rd + 1'b1;
    assign e_plus = {1'b0, e_reg} + 1'b1;
    assign cnt_prod = (COUNT_W+EXP_W+1)'(cntm_reg) * (COUNT_W+EXP_W+1)'(e_plus);
    assign cnt_prod_sat = (cnt_prod > (COUNT_W+EXP_W+1)'({COUNT_W{1'b1}})) ? '1
                          : cnt_prod[COUNT_W-1:0];

    always_comb begin
        unique case (op)
            OP_INIT:     wr_addr = AW'(1);
            OP_CLEAR:    wr_addr = clr_reg;
            OP_PRIME_WR: wr_addr = i_reg;
            default:     wr_addr = k_reg[AW-1:0];
        endcase
        unique case (op)
            OP_DV_M: tab_raddr = cof_rd;
            OP_Q_RD: tab_raddr = AW'(q_reg);
            default: tab_raddr = i_reg;
        endcase
    end

    always_comb begin
        mark_we = (op == OP_CLEAR) || k_live;
        mark_wd = (op == OP_J_K);
        spf_we = (op == OP_PRIME_WR) || k_live;
        spf_wd = (op == OP_PRIME_WR) ? i_reg : p_reg;
        exp_we = (op == OP_INIT) || (op == OP_PRIME_WR) || (k_live && !divides)
                 || (op == OP_DV_M);
        cof_we = exp_we;
        cnt_we = (op == OP_INIT) || (op == OP_PRIME_WR) || (k_live && !divides)
                 || (op == OP_DV_WR);
        ss_we = (op == OP_INIT) || (op == OP_PRIME_WR) || (op == OP_ND_WR)
                || (op == OP_DV_WR);
        pl_we = (op == OP_PRIME_WR) && !plist_full;
        exp_wd = EXP_W'(1);
        cof_wd = AW'(1);
        cnt_wd = COUNT_W'(1);
        ss_wd = SUM_W'(1);
        unique case (op)
            OP_INIT: begin
                exp_wd = '0;
            end
            OP_PRIME_WR: begin
                cnt_wd = COUNT_W'(2);
                ss_wd = add_mod(mm_res, SUM_W'(1));
            end
            OP_J_K: begin
                cof_wd = i_reg;
                cnt_wd = cnt_dbl_sat;
            end
            OP_ND_WR: begin
                ss_wd = mm_res;
            end
            OP_DV_M: begin
                exp_wd = e_new;
                cof_wd = cof_rd;
            end
            OP_DV_WR: begin
                cnt_wd = cnt_prod_sat;
                ss_wd = add_mod(mm_res, ssm_reg);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mm_start = 1'b0;
        mm_a = ss_i_reg;
        mm_b = mm_res;
        unique case (op)
            OP_CHK_I: begin
                mm_start = !mark_rd;
                mm_a = SUM_W'(i_reg);
                mm_b = SUM_W'(i_reg);
            end
            OP_J_K: begin
                mm_start = !k_stop;
                mm_a = SUM_W'(p_reg);
                mm_b = SUM_W'(p_reg);
            end
            OP_ND_ADD: begin
                mm_start = 1'b1;
                mm_b = add_mod(mm_res, SUM_W'(1));
            end
            OP_DV_MUL: begin
                mm_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    lsdf_ram #(.WIDTH(1), .DEPTH(MAX_N)) u_mark (
        .aclk(aclk), .we(mark_we), .waddr(wr_addr), .wdata(mark_wd),
        .raddr(i_reg), .rdata(mark_rd)
    );
    lsdf_ram #(.WIDTH(AW), .DEPTH(MAX_N)) u_spf (
        .aclk(aclk), .we(spf_we), .waddr(wr_addr), .wdata(spf_wd),
        .raddr(i_reg), .rdata(spf_rd)
    );
    lsdf_ram #(.WIDTH(EXP_W), .DEPTH(MAX_N)) u_exp (
        .aclk(aclk), .we(exp_we), .waddr(wr_addr), .wdata(exp_wd),
        .raddr(i_reg), .rdata(exp_rd)
    );
    lsdf_ram #(.WIDTH(AW), .DEPTH(MAX_N)) u_cof (
        .aclk(aclk), .we(cof_we), .waddr(wr_addr), .wdata(cof_wd),
        .raddr(i_reg), .rdata(cof_rd)
    );
    lsdf_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_N)) u_cnt (
        .aclk(aclk), .we(cnt_we), .waddr(wr_addr), .wdata(cnt_wd),
        .raddr(tab_raddr), .rdata(cnt_rd)
    );
    lsdf_ram #(.WIDTH(SUM_W), .DEPTH(MAX_N)) u_ss (
        .aclk(aclk), .we(ss_we), .waddr(wr_addr), .wdata(ss_wd),
        .raddr(tab_raddr), .rdata(ss_rd)
    );
    lsdf_ram #(.WIDTH(AW), .DEPTH(PRIME_DEPTH)) u_plist (
        .aclk(aclk), .we(pl_we), .waddr(ptot_reg[PAW-1:0]), .wdata(i_reg),
        .raddr(j_reg[PAW-1:0]), .rdata(pl_rd)
    );

    lsdf_mulmod u_mulmod (
        .aclk(aclk), .aresetn(aresetn), .start(mm_start), .a(mm_a), .b(mm_b),
        .busy(mm_busy), .result(mm_res)
    );

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
            blim_reg <= '0;
            ready_reg <= 1'b0;
            ptot_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (op == OP_INIT) begin
                blim_reg <= lim_clamp;
                ptot_reg <= '0;
            end
            if (op == OP_PRIME_WR && !plist_full) begin
                ptot_reg <= ptot_reg + 1'b1;
            end
            if (op == OP_DONE) begin
                ready_reg <= 1'b1;
            end
            if (op == OP_Q_OUT || op == OP_DONE) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the sieve walk and the result register.
    always_ff @(posedge aclk) begin
        case (op)
            OP_ACCEPT: q_reg <= s_query_value;
            OP_INIT: clr_reg <= '0;
            OP_CLEAR: begin
                clr_reg <= clr_reg + 1'b1;
                i_reg <= AW'(2);
            end
            OP_CHK_I: begin
                j_reg <= '0;
                if (mark_rd) begin
                    spf_i_reg <= spf_rd;
                    cnt_i_reg <= cnt_rd;
                    ss_i_reg <= ss_rd;
                end else begin
                    spf_i_reg <= i_reg;
                    cnt_i_reg <= COUNT_W'(2);
                end
            end
            OP_PRIME_WR: ss_i_reg <= add_mod(mm_res, SUM_W'(1));
            OP_J_P: begin
                p_reg <= pl_rd;
                k_reg <= (2*AW)'(i_reg) * (2*AW)'(pl_rd);
            end
            OP_ND_WR: j_reg <= j_reg + 1'b1;
            OP_DV_M: e_reg <= e_new;
            OP_DV_CAP: begin
                cntm_reg <= cnt_rd;
                ssm_reg <= ss_rd;
            end
            OP_NEXT_I: i_reg <= i_reg + 1'b1;
            OP_Q_OUT: begin
                status_reg <= q_err;
                cnt_out_reg <= q_err ? '0 : cnt_rd;
                ss_out_reg <= q_err ? '0 : ss_rd;
            end
            OP_DONE: begin
                status_reg <= 1'b0;
                cnt_out_reg <= '0;
                ss_out_reg <= '0;
            end
            default: begin
            end
        endcase
    end

    assign status.prime = !mark_rd;
    assign status.clr_last = (clr_reg == blim_reg);
    assign status.lim_small = (blim_reg < AW'(2));
    assign status.j_end = (j_reg >= ptot_reg);
    assign status.k_stop = k_stop;
    assign status.divides = divides;
    assign status.mm_busy = mm_busy;
    assign status.i_last = (i_reg == blim_reg);
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_status = status_reg;
    assign m_divisor_count = cnt_out_reg;
    assign m_divisor_square_sum = ss_out_reg;

endmodule
`default_nettype wire

// ===== hdl/lsdf_ctrl.sv =====
`default_nettype none
module lsdf_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_command,
    input  wire lsdf_pkg::dp_status_t status,
    output lsdf_pkg::dp_op_t          op
);
    import lsdf_pkg::*;

    typedef enum logic [23:0] {
        S_IDLE       = 24'h000001,
        S_Q_RD       = 24'h000002,
        S_Q_OUT      = 24'h000004,
        S_INIT       = 24'h000008,
        S_CLEAR      = 24'h000010,
        S_RD_I       = 24'h000020,
        S_CHK_I      = 24'h000040,
        S_PRIME_WAIT = 24'h000080,
        S_PRIME_WR   = 24'h000100,
        S_J_RD       = 24'h000200,
        S_J_P        = 24'h000400,
        S_J_K        = 24'h000800,
        S_ND_PP      = 24'h001000,
        S_ND_ADD     = 24'h002000,
        S_ND_WAIT    = 24'h004000,
        S_ND_WR      = 24'h008000,
        S_DV_M       = 24'h010000,
        S_DV_CAP     = 24'h020000,
        S_DV_PP      = 24'h040000,
        S_DV_MUL     = 24'h080000,
        S_DV_WAIT    = 24'h100000,
        S_DV_WR      = 24'h200000,
        S_NEXT_I     = 24'h400000,
        S_DONE       = 24'h800000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        op = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op = OP_ACCEPT;
                    state_next = s_command ? S_Q_RD : S_INIT;
                end
            end
            S_Q_RD: begin
                op = OP_Q_RD;
                state_next = S_Q_OUT;
            end
            S_Q_OUT: begin
                // While the result register is full, keep the read address.
                if (status.out_free) begin
                    op = OP_Q_OUT;
                    state_next = S_IDLE;
                end else begin
                    op = OP_Q_RD;
                end
            end
            S_INIT: begin
                op = OP_INIT;
                state_next = S_CLEAR;
            end
            S_CLEAR: begin
                op = OP_CLEAR;
                if (status.clr_last) begin
                    state_next = status.lim_small ? S_DONE : S_RD_I;
                end
            end
            S_RD_I: begin
                op = OP_RD_I;
                state_next = S_CHK_I;
            end
            S_CHK_I: begin
                op = OP_CHK_I;
                state_next = status.prime ? S_PRIME_WAIT : S_J_RD;
            end
            S_PRIME_WAIT: begin
                if (!status.mm_busy) begin
                    state_next = S_PRIME_WR;
                end
            end
            S_PRIME_WR: begin
                op = OP_PRIME_WR;
                state_next = S_J_RD;
            end
            S_J_RD: begin
                op = OP_J_RD;
                state_next = status.j_end ? S_NEXT_I : S_J_P;
            end
            S_J_P: begin
                op = OP_J_P;
                state_next = S_J_K;
            end
            S_J_K: begin
                op = OP_J_K;
                if (status.k_stop) begin
                    state_next = S_NEXT_I;
                end else if (status.divides) begin
                    state_next = S_DV_M;
                end else begin
                    state_next = S_ND_PP;
                end
            end
            S_ND_PP: begin
                if (!status.mm_busy) begin
                    state_next = S_ND_ADD;
                end
            end
            S_ND_ADD: begin
                op = OP_ND_ADD;
                state_next = S_ND_WAIT;
            end
            S_ND_WAIT: begin
                if (!status.mm_busy) begin
                    state_next = S_ND_WR;
                end
            end
            S_ND_WR: begin
                op = OP_ND_WR;
                state_next = S_J_RD;
            end
            S_DV_M: begin
                op = OP_DV_M;
                state_next = S_DV_CAP;
            end
            S_DV_CAP: begin
                op = OP_DV_CAP;
                state_next = S_DV_PP;
            end
            S_DV_PP: begin
                if (!status.mm_busy) begin
                    state_next = S_DV_MUL;
                end
            end
            S_DV_MUL: begin
                op = OP_DV_MUL;
                state_next = S_DV_WAIT;
            end
            S_DV_WAIT: begin
                if (!status.mm_busy) begin
                    state_next = S_DV_WR;
                end
            end
            S_DV_WR: begin
                op = OP_DV_WR;
                state_next = S_NEXT_I;
            end
            S_NEXT_I: begin
                op = OP_NEXT_I;
                state_next = status.i_last ? S_DONE : S_RD_I;
            end
            S_DONE: begin
                if (status.out_free) begin
                    op = OP_DONE;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule
`default_nettype wire

// ===== hdl/linear_sieve_divisor_functions.sv =====
// Divisor-function tables built by a linear sieve, with a query port.
// Requests arrive on the s_ channel (valid/ready). A request with command 0
// builds the tables for 1..sieve_limit (clamped to MAX_N-1); command 1 looks
// up s_query_value. Each request yields exactly one response on the m_
// channel: status, divisor count and sum of squared divisors mod 1000000007.
// A query reads the tables, then loads the output register once it is free;
// the next request is taken only once the block is back in idle.
// A build first sweeps the composite marks, one entry per cycle from 0
// up to the limit, then walks every n up to the limit. Each marked
// multiple costs two products of the shared bit-serial modular multiplier;
// each new prime adds one more, the product that forms its own square.
// The response waits in an output register while m_ready is low; the block
// accepts a new request meanwhile but holds its own result until the
// register frees. Synchronous reset clears the control state, sets the
// limit register to 1048575 and marks the tables unbuilt, so queries then
// report an error until a build completes. The tables themselves are not
// cleared by reset. sieve_limit is written through cfg_wr_en/cfg_wr_data.
`default_nettype none
module linear_sieve_divisor_functions #(
    parameter int MAX_N = lsdf_pkg::DEF_MAX_N,
    parameter int PRIME_DEPTH = lsdf_pkg::DEF_PRIME_DEPTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [lsdf_pkg::LIMIT_W-1:0]   cfg_wr_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_command,
    input  wire logic [lsdf_pkg::LIMIT_W-1:0]   s_query_value,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_status,
    output logic      [lsdf_pkg::COUNT_W-1:0]   m_divisor_count,
    output logic      [lsdf_pkg::SUM_W-1:0]     m_divisor_square_sum
);
    import lsdf_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    // The sequencer decides what happens each cycle; the datapath owns the
    // tables, the prime list and the modular multiplier.
    lsdf_ctrl u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .status(status),
        .op(op)
    );

    lsdf_dp #(
        .MAX_N(MAX_N),
        .PRIME_DEPTH(PRIME_DEPTH)
    ) u_dp (
        .aclk(aclk),
        .aresetn(aresetn),
        .op(op),
        .status(status),
        .s_query_value(s_query_value),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_divisor_count(m_divisor_count),
        .m_divisor_square_sum(m_divisor_square_sum)
    );

endmodule
`default_nettype wire

// ===== hdl/lsdf_chk.sv =====
`default_nettype none
module lsdf_chk (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         cfg_wr_en,
    input wire logic [lsdf_pkg::LIMIT_W-1:0] cfg_wr_data,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic                         s_command,
    input wire logic [lsdf_pkg::LIMIT_W-1:0] s_query_value,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic                         m_status,
    input wire logic [lsdf_pkg::COUNT_W-1:0] m_divisor_count,
    input wire logic [lsdf_pkg::SUM_W-1:0]   m_divisor_square_sum
);
    import lsdf_pkg::*;

    // A stalled response holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_divisor_count) && $stable(m_divisor_square_sum))
        else $error("stalled response changed");

    // Error responses carry zero values.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_divisor_count == '0 && m_divisor_square_sum == '0)
        else $error("error response with nonzero values");

    // The square sum is always a reduced residue.
    a_residue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> {1'b0, m_divisor_square_sum} < MODULUS)
        else $error("square sum not reduced");

    // No response is pending right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("response valid after reset");

endmodule

bind linear_sieve_divisor_functions lsdf_chk u_lsdf_chk (.*);
`default_nettype wire
